FILE: design/ray_triangle_hit_test_unit_defines.svh
// ----------------------------------------------------------------------------
// Ray/triangle hit test unit: assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_HIT_TEST_UNIT_DEFINES_SVH
`define RAY_TRIANGLE_HIT_TEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RTHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RTHT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RTHT_ASSERT(lbl, prop, msg)
`define RTHT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: design/rtht_pkg.sv
// ----------------------------------------------------------------------------
// Ray/triangle hit test package
// Shared constants, register codes and queue status type.
// ----------------------------------------------------------------------------
package rtht_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int DET_MIN_BITS   = 50;
  localparam int CFG_IDX_W      = 3;

  localparam logic [DET_MIN_BITS-1:0] DET_MIN_RESET = DET_MIN_BITS'(17);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5,
    CFG_DET_MIN  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: design/rtht_front.sv
// ----------------------------------------------------------------------------
// Ray/triangle hit test front end
// Accepts triangle beats, forms both edges and the origin offset, and pushes
// them into the queue.
// ----------------------------------------------------------------------------
`include "ray_triangle_hit_test_unit_defines.svh"

module rtht_front #(
  parameter int COORD_BITS = 16,
  parameter int EW         = COORD_BITS + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] v0_i [3],
  input  logic signed [COORD_BITS-1:0] v1_i [3],
  input  logic signed [COORD_BITS-1:0] v2_i [3],
  input  logic signed [COORD_BITS-1:0] origin_i [3],
  input  rtht_pkg::fifo_status_t       fifo_status_i,
  output logic                         push_o,
  output logic [9*EW-1:0]              push_data_o
);

  logic              f_valid_q, f_valid_d;
  logic [9*EW-1:0]   f_data_q, f_data_d;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] ao [3];
  logic              accept;

  assign in_stall_o  = f_valid_q && fifo_status_i.full;
  assign push_o      = f_valid_q && !fifo_status_i.full;
  assign push_data_o = f_data_q;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = EW'(v1_i[i]) - EW'(v0_i[i]);
      e2[i] = EW'(v2_i[i]) - EW'(v0_i[i]);
      ao[i] = EW'(origin_i[i]) - EW'(v0_i[i]);
    end
    f_data_d = '0;
    for (int i = 0; i < 3; i++) begin
      f_data_d[i*EW +: EW]     = e1[i];
      f_data_d[(3+i)*EW +: EW] = e2[i];
      f_data_d[(6+i)*EW +: EW] = ao[i];
    end
  end

  always_comb begin
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (push_o) begin
      f_valid_d = 1'b0;
    end else begin
      f_valid_d = f_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_data_q <= f_data_d;
    end
  end

  `RTHT_ASSERT(a_stall_only_when_held, in_stall_o |-> f_valid_q, "stall without held beat")
  `RTHT_ASSERT(a_held_beat_kept, (f_valid_q && !push_o) |=> f_valid_q, "held beat lost")

endmodule

FILE: design/rtht_fifo.sv
// ----------------------------------------------------------------------------
// Ray/triangle hit test queue
// Short register queue between the front end and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`include "ray_triangle_hit_test_unit_defines.svh"

module rtht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       push_data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       pop_data_o,
  output rtht_pkg::fifo_status_t status_o
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTRW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTRW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CNTW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `RTHT_ASSERT_NEVER(a_no_push_full, push_i && status_o.full, "push into full queue")
  `RTHT_ASSERT_NEVER(a_no_pop_empty, pop_i && status_o.empty, "pop from empty queue")

endmodule

FILE: design/rtht_back.sv
// ----------------------------------------------------------------------------
// Ray/triangle hit test pipeline
// Five stage arithmetic back end: cross products, determinant and
// barycentric numerators, then the hit decision in the output register.
// ----------------------------------------------------------------------------
`include "ray_triangle_hit_test_unit_defines.svh"

module rtht_back #(
  parameter int COORD_BITS = 16,
  parameter int EW         = COORD_BITS + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [9*EW-1:0]                   head_i,
  input  rtht_pkg::fifo_status_t            fifo_status_i,
  output logic                              pop_o,
  input  logic signed [COORD_BITS-1:0]      dir_i [3],
  input  logic [rtht_pkg::DET_MIN_BITS-1:0] det_min_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o
);

  import rtht_pkg::*;

  localparam int P1W  = 2 * COORD_BITS + 2;
  localparam int NW   = 2 * COORD_BITS + 3;
  localparam int P2W  = 3 * COORD_BITS + 4;
  localparam int SW   = 3 * COORD_BITS + 6;
  localparam int UVW  = SW + 1;
  localparam int CMPW = ((SW > DET_MIN_BITS) ? SW : DET_MIN_BITS) + 1;
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic adv;

  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];
  logic signed [EW-1:0]  ao [3];
  logic signed [P1W-1:0] pn_d [6];
  logic signed [P1W-1:0] pd_d [6];

  logic                  va_q, vb_q, vc_q, vd_q, out_valid_q;
  logic signed [P1W-1:0] pn_q [6];
  logic signed [P1W-1:0] pd_q [6];
  logic signed [EW-1:0]  a_e1_q [3];
  logic signed [EW-1:0]  a_e2_q [3];
  logic signed [EW-1:0]  a_ao_q [3];

  logic signed [NW-1:0]  n_q [3];
  logic signed [NW-1:0]  dao_q [3];
  logic signed [EW-1:0]  b_e1_q [3];
  logic signed [EW-1:0]  b_e2_q [3];
  logic signed [EW-1:0]  b_ao_q [3];

  logic signed [P2W-1:0] qd_q [3];
  logic signed [P2W-1:0] qu_q [3];
  logic signed [P2W-1:0] qv_q [3];
  logic signed [P2W-1:0] qt_q [3];

  logic signed [SW-1:0]  det_q, un_q, vn_q, tn_q;
  logic signed [SW-1:0]  det_d, un_d, vn_d, tn_d;

  logic signed [UVW-1:0]  uv_sum;
  logic signed [CMPW-1:0] det_x, det_min_x;
  logic                   hit_q, hit_d;

  assign adv         = !(out_valid_q && out_stall_i);
  assign pop_o       = adv && !fifo_status_i.empty;
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = $signed(head_i[i*EW +: EW]);
      e2[i] = $signed(head_i[(3+i)*EW +: EW]);
      ao[i] = $signed(head_i[(6+i)*EW +: EW]);
    end
    for (int i = 0; i < 3; i++) begin
      pn_d[2*i]   = P1W'(e1[NXT[i]]) * P1W'(e2[PRV[i]]);
      pn_d[2*i+1] = P1W'(e1[PRV[i]]) * P1W'(e2[NXT[i]]);
      pd_d[2*i]   = P1W'(ao[NXT[i]]) * P1W'(dir_i[PRV[i]]);
      pd_d[2*i+1] = P1W'(ao[PRV[i]]) * P1W'(dir_i[NXT[i]]);
    end
  end

  always_comb begin
    det_d = -(SW'(qd_q[0]) + SW'(qd_q[1]) + SW'(qd_q[2]));
    un_d  = SW'(qu_q[0]) + SW'(qu_q[1]) + SW'(qu_q[2]);
    vn_d  = -(SW'(qv_q[0]) + SW'(qv_q[1]) + SW'(qv_q[2]));
    tn_d  = SW'(qt_q[0]) + SW'(qt_q[1]) + SW'(qt_q[2]);
  end

  always_comb begin
    uv_sum    = UVW'(un_q) + UVW'(vn_q);
    det_x     = CMPW'(det_q);
    det_min_x = $signed(CMPW'(det_min_i));
    hit_d     = (det_q > 0) && (det_x >= det_min_x) && (tn_q >= 0) &&
                (un_q >= 0) && (vn_q >= 0) && (uv_sum <= UVW'(det_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      va_q        <= pop_o;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      vd_q        <= vc_q;
      out_valid_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        pn_q[i] <= pn_d[i];
        pd_q[i] <= pd_d[i];
      end
      for (int i = 0; i < 3; i++) begin
        a_e1_q[i] <= e1[i];
        a_e2_q[i] <= e2[i];
        a_ao_q[i] <= ao[i];
        n_q[i]    <= NW'(pn_q[2*i]) - NW'(pn_q[2*i+1]);
        dao_q[i]  <= NW'(pd_q[2*i]) - NW'(pd_q[2*i+1]);
        b_e1_q[i] <= a_e1_q[i];
        b_e2_q[i] <= a_e2_q[i];
        b_ao_q[i] <= a_ao_q[i];
        qd_q[i]   <= P2W'(dir_i[i]) * P2W'(n_q[i]);
        qu_q[i]   <= P2W'(b_e2_q[i]) * P2W'(dao_q[i]);
        qv_q[i]   <= P2W'(b_e1_q[i]) * P2W'(dao_q[i]);
        qt_q[i]   <= P2W'(b_ao_q[i]) * P2W'(n_q[i]);
      end
      det_q <= det_d;
      un_q  <= un_d;
      vn_q  <= vn_d;
      tn_q  <= tn_d;
      hit_q <= hit_d;
    end
  end

  `RTHT_ASSERT(a_last_stage_reaches_out, (vd_q && adv) |=> out_valid_q, "result dropped")
  `RTHT_ASSERT(a_stalled_result_held, (out_valid_q && out_stall_i) |=> out_valid_q,
               "stalled result lost")

endmodule

FILE: design/ray_triangle_hit_test_unit.sv
// ----------------------------------------------------------------------------
// Ray/triangle hit test unit
// Front-face Moller-Trumbore test of a stream of triangles against one ray.
// ----------------------------------------------------------------------------
// Takes one triangle (three Q8.8 vertices) per beat and returns one hit flag
// per triangle, in order, against the ray and determinant threshold held in
// the configuration registers. It sustains one triangle per clock while the
// output is not stalled: every multiplier sits in a fully pipelined five stage
// back end, fed from a four entry queue behind a one stage front end that
// forms the edges. The queue lets the front keep taking beats while results
// are held, until the queue fills.
// Write the registers only while no triangle is in flight.
module ray_triangle_hit_test_unit #(
  parameter int COORD_BITS = rtht_pkg::COORD_BITS_DEF,
  parameter int FIFO_DEPTH = rtht_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      v0_x_i,
  input  logic signed [COORD_BITS-1:0]      v0_y_i,
  input  logic signed [COORD_BITS-1:0]      v0_z_i,
  input  logic signed [COORD_BITS-1:0]      v1_x_i,
  input  logic signed [COORD_BITS-1:0]      v1_y_i,
  input  logic signed [COORD_BITS-1:0]      v1_z_i,
  input  logic signed [COORD_BITS-1:0]      v2_x_i,
  input  logic signed [COORD_BITS-1:0]      v2_y_i,
  input  logic signed [COORD_BITS-1:0]      v2_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rtht_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rtht_pkg::DET_MIN_BITS-1:0] cfg_data_i
);

  import rtht_pkg::*;

  localparam int EW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] origin_q [3];
  logic signed [COORD_BITS-1:0] dir_q [3];
  logic [DET_MIN_BITS-1:0]      det_min_q;
  logic signed [COORD_BITS-1:0] v0 [3];
  logic signed [COORD_BITS-1:0] v1 [3];
  logic signed [COORD_BITS-1:0] v2 [3];
  logic signed [COORD_BITS-1:0] cfg_coord;
  logic                         cfg_we;

  logic            push, pop;
  logic [9*EW-1:0] push_data, head;
  fifo_status_t    fifo_status;

  assign v0 = '{v0_x_i, v0_y_i, v0_z_i};
  assign v1 = '{v1_x_i, v1_y_i, v1_z_i};
  assign v2 = '{v2_x_i, v2_y_i, v2_z_i};

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_coord   = $signed(cfg_data_i[COORD_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        dir_q[i]    <= '0;
      end
      det_min_q <= DET_MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ORIGIN_X: origin_q[0] <= cfg_coord;
        CFG_ORIGIN_Y: origin_q[1] <= cfg_coord;
        CFG_ORIGIN_Z: origin_q[2] <= cfg_coord;
        CFG_DIR_X:    dir_q[0]    <= cfg_coord;
        CFG_DIR_Y:    dir_q[1]    <= cfg_coord;
        CFG_DIR_Z:    dir_q[2]    <= cfg_coord;
        CFG_DET_MIN:  det_min_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rtht_front #(
    .COORD_BITS (COORD_BITS),
    .EW         (EW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .v0_i          (v0),
    .v1_i          (v1),
    .v2_i          (v2),
    .origin_i      (origin_q),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  rtht_fifo #(
    .WIDTH (9 * EW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (head),
    .status_o    (fifo_status)
  );

  rtht_back #(
    .COORD_BITS (COORD_BITS),
    .EW         (EW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .dir_i         (dir_q),
    .det_min_i     (det_min_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o)
  );

endmodule
